@@ design/akf_pkg.sv @@
// shared types, constants and fixed-point helpers for the angle kalman filter
package akf_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WIDE_W = 66;

   typedef struct packed {
      logic signed [31:0] rate_step;
      logic signed [31:0] measured_angle;
      logic [15:0]        sample_interval;
   } akf_req_type;

   typedef struct packed {
      logic signed [31:0] angle_estimate;
      logic signed [31:0] rate_estimate;
   } akf_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } akf_state_type;

   // datapath steps, issued in this order
   typedef enum logic [4:0] {
      OP_NOP,
      OP_M_T1, OP_A_T1,
      OP_M_T2, OP_A_T2,
      OP_M_T3, OP_A_T3,
      OP_M_T4, OP_A_T4,
      OP_M_T5, OP_A_T5,
      OP_M_T6, OP_A_T6,
      OP_NOISE,
      OP_SCALC,
      OP_DIV_START,
      OP_DIV_WAIT,
      OP_GAIN,
      OP_M_C0, OP_A_C0,
      OP_M_C1, OP_A_C1,
      OP_M_C2, OP_A_C2,
      OP_M_C3, OP_A_C3,
      OP_M_C4, OP_A_C4,
      OP_M_C5, OP_A_C5
   } akf_op_type;

   typedef struct packed {
      akf_op_type op;
      logic       load;
      logic       load_out;
   } akf_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } akf_status_type;

   localparam logic signed [WIDE_W-1:0] MAX32 = $signed({34'b0, 32'h7FFF_FFFF});
   localparam logic signed [WIDE_W-1:0] MIN32 = $signed({{34{1'b1}}, 32'h8000_0000});

   function automatic logic signed [WIDE_W-1:0] ext32(input logic signed [31:0] v);
      return $signed({{(WIDE_W-32){v[31]}}, v});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > MAX32) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < MIN32) begin
         r = $signed(32'h8000_0000);
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // round half up, then floor shift
   function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [64:0] p,
                                                     input int sh);
      logic signed [WIDE_W-1:0] w;
      w = $signed({p[64], p}) + ($signed(66'sd1) <<< (sh - 1));
      return w >>> sh;
   endfunction

endpackage

@@ design/akf_divider.sv @@
// two-lane restoring divider for the gains, one quotient bit per cycle
module akf_divider #(
   parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [31:0]                 num0,
   input  logic signed [31:0]                 num1,
   input  logic [31:0]                        den,
   output logic                               done,
   output logic signed [akf_pkg::WIDE_W-1:0]  quot0,
   output logic signed [akf_pkg::WIDE_W-1:0]  quot1
);

   localparam int NB = 32 + FRAC_BITS;
   localparam int CW = $clog2(NB + 1);

   logic [NB-1:0] dvd0_ff, dvd1_ff;
   logic [31:0]   rem0_ff, rem1_ff;
   logic          neg0_ff, neg1_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;

   logic [31:0] mag0, mag1;
   logic [32:0] sh0, sh1;
   logic [33:0] diff0, diff1;

   always_comb begin
      mag0  = num0[31] ? 32'(-num0) : 32'(num0);
      mag1  = num1[31] ? 32'(-num1) : 32'(num1);
      sh0   = {rem0_ff, dvd0_ff[NB-1]};
      sh1   = {rem1_ff, dvd1_ff[NB-1]};
      diff0 = {1'b0, sh0} - {2'b0, den};
      diff1 = {1'b0, sh1} - {2'b0, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(NB);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd0_ff <= {mag0, {FRAC_BITS{1'b0}}};
         dvd1_ff <= {mag1, {FRAC_BITS{1'b0}}};
         rem0_ff <= '0;
         rem1_ff <= '0;
         neg0_ff <= num0[31];
         neg1_ff <= num1[31];
      end else if (busy_ff) begin
         if (!diff0[33]) begin
            rem0_ff <= diff0[31:0];
         end else begin
            rem0_ff <= sh0[31:0];
         end
         if (!diff1[33]) begin
            rem1_ff <= diff1[31:0];
         end else begin
            rem1_ff <= sh1[31:0];
         end
         dvd0_ff <= {dvd0_ff[NB-2:0], ~diff0[33]};
         dvd1_ff <= {dvd1_ff[NB-2:0], ~diff1[33]};
      end
   end

   // quotient truncates toward zero: divide magnitudes, then restore the sign
   always_comb begin
      quot0 = $signed({{(akf_pkg::WIDE_W-NB){1'b0}}, dvd0_ff});
      quot1 = $signed({{(akf_pkg::WIDE_W-NB){1'b0}}, dvd1_ff});
      if (neg0_ff) quot0 = -quot0;
      if (neg1_ff) quot1 = -quot1;
   end

   assign done = done_ff;

endmodule

@@ design/akf_ctrl.sv @@
// sequencer that walks the datapath through one filter update
module akf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  akf_pkg::akf_status_type status,
   output akf_pkg::akf_cmd_type    cmd
);

   akf_pkg::akf_state_type state_ff, state_in;
   akf_pkg::akf_op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= akf_pkg::ST_IDLE;
         op_ff    <= akf_pkg::OP_NOP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cmd.op       = akf_pkg::OP_NOP;
      cmd.load     = 1'b0;
      cmd.load_out = 1'b0;
      req_stall    = 1'b1;
      unique case (state_ff)
         akf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = akf_pkg::ST_RUN;
               op_in    = akf_pkg::OP_M_T1;
            end
         end
         akf_pkg::ST_RUN: begin
            cmd.op = op_ff;
            if (op_ff == akf_pkg::OP_A_C5) begin
               state_in = akf_pkg::ST_DONE;
               op_in    = akf_pkg::OP_NOP;
            end else if (op_ff != akf_pkg::OP_DIV_WAIT || status.div_done) begin
               op_in = akf_pkg::akf_op_type'(op_ff + 5'd1);
            end
         end
         akf_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = akf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = akf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/akf_datapath.sv @@
// filter state, shared multiplier, gain divider and result register
module akf_datapath #(
   parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  akf_pkg::akf_cmd_type    cmd,
   output akf_pkg::akf_status_type status,
   input  akf_pkg::akf_req_type    req_data,
   input  logic [30:0]             measure_noise,
   input  logic [30:0]             model_noise,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output akf_pkg::akf_rsp_type    rsp_data
);

   localparam int W = akf_pkg::WIDE_W;
   localparam logic signed [W-1:0] ONE_Q = $signed(66'sd1) <<< FRAC_BITS;

   logic signed [31:0] g_ff, z_ff;
   logic [15:0]        ts_ff;
   logic signed [31:0] x0_ff, x1_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] xp0_ff, xp1_ff, m00_ff, m01_ff, m10_ff, m11_ff;
   logic signed [31:0] t3s_ff, s_ff, y_ff, k0_ff, k1_ff, omk_ff;
   logic               spos_ff;
   logic signed [W-1:0] acc_ff;
   logic signed [64:0]  prod_ff, prod_in;
   logic signed [31:0]  mul_a;
   logic signed [32:0]  mul_b;
   logic signed [W-1:0] r16, r17, rq;
   logic                rsp_valid_ff;
   akf_pkg::akf_rsp_type rsp_ff;

   logic                div_done;
   logic signed [W-1:0] quot0, quot1;
   logic signed [32:0]  ts_s;

   akf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == akf_pkg::OP_DIV_START),
      .num0  (m00_ff),
      .num1  (m10_ff),
      .den   (s_ff),
      .done  (div_done),
      .quot0 (quot0),
      .quot1 (quot1)
   );

   assign ts_s = $signed({17'b0, ts_ff});

   // operand select for the shared multiplier
   always_comb begin
      mul_a = x1_ff;
      mul_b = ts_s;
      case (cmd.op)
         akf_pkg::OP_M_T2: mul_a = g_ff;
         akf_pkg::OP_M_T3: mul_a = p11_ff;
         akf_pkg::OP_M_T4: mul_a = p10_ff;
         akf_pkg::OP_M_T5: mul_a = p01_ff;
         akf_pkg::OP_M_T6: mul_a = t3s_ff;
         akf_pkg::OP_M_C0: begin mul_a = k0_ff;  mul_b = {y_ff[31], y_ff};     end
         akf_pkg::OP_M_C1: begin mul_a = k1_ff;  mul_b = {y_ff[31], y_ff};     end
         akf_pkg::OP_M_C2: begin mul_a = omk_ff; mul_b = {m00_ff[31], m00_ff}; end
         akf_pkg::OP_M_C3: begin mul_a = omk_ff; mul_b = {m01_ff[31], m01_ff}; end
         akf_pkg::OP_M_C4: begin mul_a = k1_ff;  mul_b = {m00_ff[31], m00_ff}; end
         akf_pkg::OP_M_C5: begin mul_a = k1_ff;  mul_b = {m01_ff[31], m01_ff}; end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
      r16 = akf_pkg::rnd(prod_ff, 16);
      r17 = akf_pkg::rnd(prod_ff, 17);
      rq  = akf_pkg::rnd(prod_ff, FRAC_BITS);
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff  <= '0;
         x1_ff  <= '0;
         p00_ff <= '0;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= '0;
      end else begin
         case (cmd.op)
            akf_pkg::OP_A_C0: x0_ff  <= akf_pkg::sat32(akf_pkg::ext32(xp0_ff) + rq);
            akf_pkg::OP_A_C1: x1_ff  <= akf_pkg::sat32(akf_pkg::ext32(xp1_ff) + rq);
            akf_pkg::OP_A_C2: p00_ff <= akf_pkg::sat32(rq);
            akf_pkg::OP_A_C3: p01_ff <= akf_pkg::sat32(rq);
            akf_pkg::OP_A_C4: p10_ff <= akf_pkg::sat32(akf_pkg::ext32(m10_ff) - rq);
            akf_pkg::OP_A_C5: p11_ff <= akf_pkg::sat32(akf_pkg::ext32(m11_ff) - rq);
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         g_ff  <= req_data.rate_step;
         z_ff  <= req_data.measured_angle;
         ts_ff <= req_data.sample_interval;
      end
      case (cmd.op)
         akf_pkg::OP_A_T1: acc_ff <= akf_pkg::ext32(x0_ff) + r16;
         akf_pkg::OP_A_T2: begin
            xp0_ff <= akf_pkg::sat32(acc_ff + r17);
            xp1_ff <= akf_pkg::sat32(akf_pkg::ext32(x1_ff) + akf_pkg::ext32(g_ff));
         end
         akf_pkg::OP_A_T3: begin
            t3s_ff <= akf_pkg::sat32(r16);
            m01_ff <= akf_pkg::sat32(akf_pkg::ext32(p01_ff) + r16);
            m10_ff <= akf_pkg::sat32(akf_pkg::ext32(p10_ff) + r16);
         end
         akf_pkg::OP_A_T4: acc_ff <= akf_pkg::ext32(p00_ff) + r16;
         akf_pkg::OP_A_T5: acc_ff <= acc_ff + r16;
         akf_pkg::OP_A_T6: m00_ff <= akf_pkg::sat32(acc_ff + r16);
         akf_pkg::OP_NOISE: begin
            m00_ff <= akf_pkg::sat32(akf_pkg::ext32(m00_ff) + $signed({35'b0, model_noise}));
            m11_ff <= akf_pkg::sat32(akf_pkg::ext32(p11_ff) + $signed({35'b0, model_noise}));
         end
         akf_pkg::OP_SCALC: begin
            s_ff <= akf_pkg::sat32(akf_pkg::ext32(m00_ff) + $signed({35'b0, measure_noise}));
            y_ff <= akf_pkg::sat32(akf_pkg::ext32(z_ff) - akf_pkg::ext32(xp0_ff));
         end
         akf_pkg::OP_DIV_START: spos_ff <= !s_ff[31] && (s_ff != '0);
         akf_pkg::OP_GAIN: begin
            // non-positive innovation variance leaves the prediction uncorrected
            k0_ff <= spos_ff ? akf_pkg::sat32(quot0) : '0;
            k1_ff <= spos_ff ? akf_pkg::sat32(quot1) : '0;
         end
         akf_pkg::OP_A_C0: omk_ff <= akf_pkg::sat32(ONE_Q - akf_pkg::ext32(k0_ff));
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.angle_estimate <= x0_ff;
         rsp_ff.rate_estimate  <= x1_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

@@ design/angle_kalman_filter.sv @@
// two-state tilt angle kalman filter, top level with register port
//
// each item on the req_ channel carries a gyro rate step, an accelerometer
// angle and the sample interval; it yields one item on the rsp_ channel with
// the corrected angle and rate. an item is taken when valid is high and stall
// is low. one item is worked on at a time: 28 sequencer steps around a
// shared 32x33 multiplier, a wait on a two-lane restoring divider and
// a load of the output register; the next item can be accepted once the
// result is in the output register. the output register holds a result
// while the receiver stalls and the next item is already accepted
// meanwhile; a finished item then waits until the register frees.
// reset clears the state and covariance to zero and loads the noise
// registers with 0.1 and 0.01 in fixed point. noise registers sit at byte
// address 0 (measure noise) and 4 (model noise) and are to be written only
// while idle by the user; the block itself does not enforce this.
module angle_kalman_filter #(
   parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  akf_pkg::akf_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output akf_pkg::akf_rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam logic [30:0] MEASURE_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 10);
   localparam logic [30:0] MODEL_RESET   = 31'(((64'd1 << FRAC_BITS) + 64'd50) / 100);
   localparam logic REG_MEASURE_NOISE = 1'b0;
   localparam logic REG_MODEL_NOISE   = 1'b1;

   logic [30:0] measure_noise_ff, model_noise_ff;
   logic        csr_write;

   akf_pkg::akf_cmd_type    cmd;
   akf_pkg::akf_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         measure_noise_ff <= MEASURE_RESET;
         model_noise_ff   <= MODEL_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MEASURE_NOISE: measure_noise_ff <= csr_pwdata[30:0];
            REG_MODEL_NOISE:   model_noise_ff   <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MEASURE_NOISE: csr_prdata = {1'b0, measure_noise_ff};
         REG_MODEL_NOISE:   csr_prdata = {1'b0, model_noise_ff};
         default:           csr_prdata = '0;
      endcase
   end

   akf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   akf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .measure_noise (measure_noise_ff),
      .model_noise   (model_noise_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

@@ tb/sv/tb_angle_kalman_filter.sv @@
// testbench for the angle kalman filter: directed table, then random items checked by a predictor
module tb_angle_kalman_filter;

   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] ADDR_MEASURE_NOISE = 3'd0;
   localparam logic [2:0] ADDR_MODEL_NOISE = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   akf_pkg::akf_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   akf_pkg::akf_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   angle_kalman_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // filter state mirrored in the testbench
   logic [30:0] meas_noise_q, model_noise_q;
   logic signed [31:0] angle_q, rate_q, p00_q, p01_q, p10_q, p11_q;

   akf_pkg::akf_rsp_type estimate_queue[$];
   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;

   typedef struct {
      akf_pkg::akf_req_type item;
      logic                 has_expect;
      akf_pkg::akf_rsp_type want;
   } vector_type;

   function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -128'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [127:0] qprod(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b) + (128'sd1 <<< (FRAC - 1));
      return p >>> FRAC;
   endfunction

   function automatic logic signed [127:0] tprod(input logic signed [31:0] a,
                                                  input logic [15:0] ts, input int sh);
      logic signed [127:0] p;
      p = 128'(a) * $signed({112'd0, ts}) + (128'sd1 <<< (sh - 1));
      return p >>> sh;
   endfunction

   function automatic logic signed [31:0] kalman_gain(input logic signed [31:0] num,
                                                       input logic signed [31:0] s);
      logic signed [127:0] n;
      if (s <= 0) return '0;
      n = 128'(num) <<< FRAC;
      return clamp32(n / 128'(s));
   endfunction

   task automatic filter_step(input akf_pkg::akf_req_type r,
                              output akf_pkg::akf_rsp_type o);
      logic signed [31:0] xp0, xp1, m00, m01, m10, m11, s, k0, k1, y, omk, tp11;
      logic [15:0] ts;
      ts = r.sample_interval;
      xp0 = clamp32(128'(angle_q) + tprod(rate_q, ts, 16) + tprod(r.rate_step, ts, 17));
      xp1 = clamp32(128'(rate_q) + 128'(r.rate_step));
      tp11 = clamp32(tprod(p11_q, ts, 16));
      m01 = clamp32(128'(p01_q) + tprod(p11_q, ts, 16));
      m10 = clamp32(128'(p10_q) + tprod(p11_q, ts, 16));
      m00 = clamp32(128'(p00_q) + tprod(p10_q, ts, 16) + tprod(p01_q, ts, 16)
                    + tprod(tp11, ts, 16));
      m00 = clamp32(128'(m00) + $signed({97'd0, model_noise_q}));
      m11 = clamp32(128'(p11_q) + $signed({97'd0, model_noise_q}));
      s = clamp32(128'(m00) + $signed({97'd0, meas_noise_q}));
      k0 = kalman_gain(m00, s);
      k1 = kalman_gain(m10, s);
      y = clamp32(128'(r.measured_angle) - 128'(xp0));
      angle_q = clamp32(128'(xp0) + qprod(k0, y));
      rate_q = clamp32(128'(xp1) + qprod(k1, y));
      omk = clamp32((128'sd1 <<< FRAC) - 128'(k0));
      p00_q = clamp32(qprod(omk, m00));
      p01_q = clamp32(qprod(omk, m01));
      p10_q = clamp32(128'(m10) - qprod(k1, m00));
      p11_q = clamp32(128'(m11) - qprod(k1, m01));
      o.angle_estimate = angle_q;
      o.rate_estimate = rate_q;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // result side: random stalls, compare against oldest expected estimate
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (estimate_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.angle_estimate, '0);
         end else begin
            if (rsp_data.angle_estimate !== estimate_queue[0].angle_estimate)
               report_mismatch("angle_estimate", rsp_data.angle_estimate,
                               estimate_queue[0].angle_estimate);
            if (rsp_data.rate_estimate !== estimate_queue[0].rate_estimate)
               report_mismatch("rate_estimate", rsp_data.rate_estimate,
                               estimate_queue[0].rate_estimate);
            void'(estimate_queue.pop_front());
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_MEASURE_NOISE) meas_noise_q = value[30:0];
      else model_noise_q = value[30:0];
   endtask

   task automatic drain_filter();
      while (estimate_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // drops req_valid for random idle gaps before an item, then holds it until the item is taken
   task automatic send_item(input akf_pkg::akf_req_type item, input logic has_expect,
                            input akf_pkg::akf_rsp_type want);
      akf_pkg::akf_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      filter_step(item, predicted);
      if (has_expect && predicted !== want)
         report_mismatch("directed row", predicted.angle_estimate, want.angle_estimate);
      estimate_queue.push_back(predicted);
   endtask

   function automatic akf_pkg::akf_req_type random_item(input int style);
      akf_pkg::akf_req_type r;
      r.rate_step = $urandom;
      r.measured_angle = $urandom;
      r.sample_interval = 16'($urandom);
      if (style < 70) begin
         // realistic imu stream: small increments, interval of at most 2000
         r.rate_step = $signed($urandom_range(0, 131072)) - 65536;
         r.measured_angle = ($signed($urandom_range(0, 180)) - 90) <<< FRAC;
         r.sample_interval = 16'($urandom_range(0, 2000));
      end else if (style < 85) begin
         r.sample_interval = 16'($urandom_range(0, 65535));
      end
      return r;
   endfunction

   vector_type directed[10] = '{
      '{'{32'sd0, 32'sd0, 16'd0}, 1'b1, '{32'sd0, 32'sd0}},
      '{'{32'sd0, 32'sd0, 16'd65}, 1'b1, '{32'sd0, 32'sd0}},
      '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{32'sh8000_0000, 32'sh8000_0000, 16'hFFFF}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 16'h8000}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{32'sd65536, 32'sd655360, 16'd66}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{-32'sd65536, -32'sd655360, 16'd66}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{32'sd0, 32'sd0, 16'd1}, 1'b0, '{32'sd0, 32'sd0}},
      '{'{32'sd1, -32'sd1, 16'h7FFF}, 1'b0, '{32'sd0, 32'sd0}}
   };

   initial begin
      akf_pkg::akf_rsp_type none;
      int phase;
      none = '0;
      meas_noise_q = 31'd6554;
      model_noise_q = 31'd655;
      {angle_q, rate_q, p00_q, p01_q, p10_q, p11_q} = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i].item, directed[i].has_expect,
                                      directed[i].want);
      req_valid <= 1'b0;
      drain_filter();

      // zero measure noise: non-positive innovation variance path via zero model noise
      csr_write(ADDR_MEASURE_NOISE, 32'd0);
      csr_write(ADDR_MODEL_NOISE, 32'd0);
      for (int i = 0; i < 6; i++)
         send_item(random_item(i * 20), 1'b0, none);
      req_valid <= 1'b0;
      drain_filter();
      csr_write(ADDR_MEASURE_NOISE, 32'hFFFF_FFFF);
      csr_write(ADDR_MODEL_NOISE, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++)
         send_item(random_item(i * 20), 1'b0, none);
      req_valid <= 1'b0;
      drain_filter();

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 33 : 0;
         csr_write(ADDR_MEASURE_NOISE, (phase == 1) ? 32'd1 : $urandom_range(1, 400000));
         csr_write(ADDR_MODEL_NOISE, (phase == 2) ? 32'd655 : $urandom_range(0, 70000));
         for (int i = 0; i < 460; i++) begin
            send_item(random_item($urandom_range(0, 99)), 1'b0, none);
            if (i == 200) begin
               // sender holds off until every estimate is back
               req_valid <= 1'b0;
               while (estimate_queue.size() != 0) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
         drain_filter();
      end

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ files.f @@
design/akf_pkg.sv
design/akf_divider.sv
design/akf_ctrl.sv
design/akf_datapath.sv
design/angle_kalman_filter.sv
tb/sv/tb_angle_kalman_filter.sv
